// ===== src/hsvrgb_pkg.sv =====
package hsvrgb_pkg;

   // Hue limit and largest offset within a sector, in degrees
   localparam logic [8:0] HUE_MAX    = 9'd359;
   localparam logic [5:0] SECTOR_DEG = 6'd59;

   // Division by 60 as multiply by ceil(2^20/60) and shift by 20.
   // Exact for dividends below 2^20/44, which covers 255*59.
   localparam logic [14:0] RECIP_60    = 15'd17477;
   localparam int          RECIP_SHIFT = 20;

   // Sector codes
   localparam logic [2:0] SECT_RY = 3'd0;
   localparam logic [2:0] SECT_YG = 3'd1;
   localparam logic [2:0] SECT_GC = 3'd2;
   localparam logic [2:0] SECT_CB = 3'd3;
   localparam logic [2:0] SECT_BM = 3'd4;
   localparam logic [2:0] SECT_MR = 3'd5;

   typedef struct packed {
      logic signed [10:0] led_index;
      logic [9:0]         hue;
      logic [7:0]         saturation;
      logic [7:0]         brightness;
   } req_type;

   typedef struct packed {
      logic       write_enable;
      logic [9:0] led_slot;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_type;

endpackage

// ===== src/hsv_to_rgb_pixel_color_core.sv =====
// Throughput: one item per cycle; each stage holds its item only while the
// stage after it is full and blocked, so bubbles collapse under stall.
// Stages: hue split, saturation products, divide by 60, brightness scale, mux.
// Reset: synchronous, active high; clears all stage valid bits.
module hsv_to_rgb_pixel_color_core #(
   parameter int LED_COUNT = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  hsvrgb_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output hsvrgb_pkg::rsp_type rsp_data
);
   import hsvrgb_pkg::*;

   // Stage valid bits and per-stage load enables
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic v1_in, v2_in, v3_in, v4_in, v5_in;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   always_comb begin
      rdy5 = !v5_ff || !rsp_stall;
      rdy4 = !v4_ff || rdy5;
      rdy3 = !v3_ff || rdy4;
      rdy2 = !v2_ff || rdy3;
      rdy1 = !v1_ff || rdy2;
   end

   assign req_stall = !rdy1;
   assign rsp_valid = v5_ff;

   assign v1_in = rdy1 ? req_valid : v1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;
   assign v3_in = rdy3 ? v2_ff : v3_ff;
   assign v4_in = rdy4 ? v3_ff : v4_ff;
   assign v5_in = rdy5 ? v4_ff : v5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         v5_ff <= v5_in;
      end
   end

   // ---------------- Stage 1: range check, hue clamp and sector split
   logic       en1_ff, en1_in;
   logic [9:0] slot1_ff, slot1_in;
   logic [2:0] sect1_ff, sect1_in;
   logic [5:0] frac1_ff, frac1_in;
   logic [7:0] sat1_ff, bri1_ff;
   logic [8:0] hue_c;
   logic [8:0] sect_base;

   always_comb begin
      en1_in = !req_data.led_index[10] &&
               ({1'b0, req_data.led_index[9:0]} < 11'(LED_COUNT));
      slot1_in = en1_in ? req_data.led_index[9:0] : 10'd0;
      hue_c = (req_data.hue > 10'(HUE_MAX)) ? HUE_MAX : req_data.hue[8:0];
      if (hue_c >= 9'd300) begin
         sect1_in = SECT_MR; sect_base = 9'd300;
      end else if (hue_c >= 9'd240) begin
         sect1_in = SECT_BM; sect_base = 9'd240;
      end else if (hue_c >= 9'd180) begin
         sect1_in = SECT_CB; sect_base = 9'd180;
      end else if (hue_c >= 9'd120) begin
         sect1_in = SECT_GC; sect_base = 9'd120;
      end else if (hue_c >= 9'd60) begin
         sect1_in = SECT_YG; sect_base = 9'd60;
      end else begin
         sect1_in = SECT_RY; sect_base = 9'd0;
      end
      frac1_in = 6'(hue_c - sect_base);
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         en1_ff   <= en1_in;
         slot1_ff <= slot1_in;
         sect1_ff <= sect1_in;
         frac1_ff <= frac1_in;
         sat1_ff  <= req_data.saturation;
         bri1_ff  <= req_data.brightness;
      end
   end

   // ---------------- Stage 2: saturation times fraction products
   logic        en2_ff;
   logic [9:0]  slot2_ff;
   logic [2:0]  sect2_ff;
   logic        grey2_ff;
   logic [7:0]  bri2_ff, isat2_ff;
   logic [13:0] pq2_ff, pt2_ff, pq2_in, pt2_in;

   assign pq2_in = 14'(sat1_ff) * 14'(frac1_ff);
   assign pt2_in = 14'(sat1_ff) * 14'(SECTOR_DEG - frac1_ff);

   always_ff @(posedge clock) begin
      if (rdy2) begin
         en2_ff   <= en1_ff;
         slot2_ff <= slot1_ff;
         sect2_ff <= sect1_ff;
         grey2_ff <= (sat1_ff == 8'd0);
         bri2_ff  <= bri1_ff;
         isat2_ff <= 8'd255 - sat1_ff;
         pq2_ff   <= pq2_in;
         pt2_ff   <= pt2_in;
      end
   end

   // ---------------- Stage 3: divide by 60, brightness times (255 - s)
   logic        en3_ff;
   logic [9:0]  slot3_ff;
   logic [2:0]  sect3_ff;
   logic        grey3_ff;
   logic [7:0]  bri3_ff;
   logic [7:0]  qq3_ff, qt3_ff;
   logic [15:0] pp3_ff;
   logic [28:0] rq_full, rt_full;

   assign rq_full = 29'(pq2_ff) * 29'(RECIP_60);
   assign rt_full = 29'(pt2_ff) * 29'(RECIP_60);

   always_ff @(posedge clock) begin
      if (rdy3) begin
         en3_ff   <= en2_ff;
         slot3_ff <= slot2_ff;
         sect3_ff <= sect2_ff;
         grey3_ff <= grey2_ff;
         bri3_ff  <= bri2_ff;
         qq3_ff   <= rq_full[RECIP_SHIFT +: 8];
         qt3_ff   <= rt_full[RECIP_SHIFT +: 8];
         pp3_ff   <= 16'(bri2_ff) * 16'(isat2_ff);
      end
   end

   // ---------------- Stage 4: scale q and t by brightness
   logic        en4_ff;
   logic [9:0]  slot4_ff;
   logic [2:0]  sect4_ff;
   logic        grey4_ff;
   logic [7:0]  bri4_ff, p4_ff, q4_ff, t4_ff;
   logic [15:0] q_full, t_full;

   assign q_full = 16'(bri3_ff) * 16'(8'd255 - qq3_ff);
   assign t_full = 16'(bri3_ff) * 16'(8'd255 - qt3_ff);

   always_ff @(posedge clock) begin
      if (rdy4) begin
         en4_ff   <= en3_ff;
         slot4_ff <= slot3_ff;
         sect4_ff <= sect3_ff;
         grey4_ff <= grey3_ff;
         bri4_ff  <= bri3_ff;
         p4_ff    <= pp3_ff[15:8];
         q4_ff    <= q_full[15:8];
         t4_ff    <= t_full[15:8];
      end
   end

   // ---------------- Stage 5: sector mapping into the output register
   rsp_type rsp_ff, rsp_in;

   always_comb begin
      rsp_in.write_enable = en4_ff;
      rsp_in.led_slot     = slot4_ff;
      case (sect4_ff)
         SECT_RY: begin
            rsp_in.red = bri4_ff; rsp_in.green = t4_ff;   rsp_in.blue = p4_ff;
         end
         SECT_YG: begin
            rsp_in.red = q4_ff;   rsp_in.green = bri4_ff; rsp_in.blue = p4_ff;
         end
         SECT_GC: begin
            rsp_in.red = p4_ff;   rsp_in.green = bri4_ff; rsp_in.blue = t4_ff;
         end
         SECT_CB: begin
            rsp_in.red = p4_ff;   rsp_in.green = q4_ff;   rsp_in.blue = bri4_ff;
         end
         SECT_BM: begin
            rsp_in.red = t4_ff;   rsp_in.green = p4_ff;   rsp_in.blue = bri4_ff;
         end
         default: begin
            rsp_in.red = bri4_ff; rsp_in.green = p4_ff;   rsp_in.blue = q4_ff;
         end
      endcase
      // grey overrides the sector
      if (grey4_ff) begin
         rsp_in.red   = bri4_ff;
         rsp_in.green = bri4_ff;
         rsp_in.blue  = bri4_ff;
      end
      // suppressed write gives zero color
      if (!en4_ff) begin
         rsp_in.red   = 8'd0;
         rsp_in.green = 8'd0;
         rsp_in.blue  = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy5) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== verif/hsv_to_rgb_pixel_color_core_test.sv =====
`timescale 1ns / 100ps

module hsv_to_rgb_pixel_color_core_test;
   import hsvrgb_pkg::*;

   localparam int LED_COUNT    = 256;
   localparam int RANDOM_ITEMS = 450;
   localparam int CALM_TAIL    = 80;      // last items go without idling
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 20;
   localparam int REPORT_MAX   = 10;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   req_type pending_pixels[$];
   rsp_type predicted_colors[$];
   int      mismatch_count = 0;
   int      colors_seen    = 0;
   int      gap_left       = 0;
   int      stall_left     = 0;
   int      cycle_count    = 0;

   hsv_to_rgb_pixel_color_core #(
      .LED_COUNT(LED_COUNT)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always #5 clock = ~clock;

   // Expected color for one pixel request, six-sector integer HSV scheme
   function automatic rsp_type hsv_pixel_color(req_type px);
      rsp_type     color;
      int          slot;
      int unsigned h, s, v, f, p, q, t;
      logic [2:0]  sector;
      color = '0;
      slot  = {{21{px.led_index[10]}}, px.led_index};
      if (slot < 0 || slot >= LED_COUNT) begin
         return color;
      end
      color.write_enable = 1'b1;
      color.led_slot     = slot[9:0];
      s = px.saturation;
      v = px.brightness;
      if (s == 0) begin
         color.red   = v[7:0];
         color.green = v[7:0];
         color.blue  = v[7:0];
         return color;
      end
      h = (px.hue > 359) ? 359 : px.hue;
      sector = 3'(h / 60);
      f = h % 60;
      p = v * (255 - s) / 256;
      q = v * (255 - s * f / 60) / 256;
      t = v * (255 - s * (59 - f) / 60) / 256;
      case (sector)
         SECT_RY: begin color.red = v[7:0]; color.green = t[7:0]; color.blue = p[7:0]; end
         SECT_YG: begin color.red = q[7:0]; color.green = v[7:0]; color.blue = p[7:0]; end
         SECT_GC: begin color.red = p[7:0]; color.green = v[7:0]; color.blue = t[7:0]; end
         SECT_CB: begin color.red = p[7:0]; color.green = q[7:0]; color.blue = v[7:0]; end
         SECT_BM: begin color.red = t[7:0]; color.green = p[7:0]; color.blue = v[7:0]; end
         default: begin color.red = v[7:0]; color.green = p[7:0]; color.blue = q[7:0]; end
      endcase
      return color;
   endfunction

   function automatic req_type make_pixel(int slot, int h, int s, int v);
      req_type px;
      px.led_index  = 11'(slot);
      px.hue        = 10'(h);
      px.saturation = 8'(s);
      px.brightness = 8'(v);
      return px;
   endfunction

   // Mostly well-formed pixels; the rest is noise over the full field ranges
   function automatic req_type random_pixel();
      req_type px;
      px.brightness = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 80) begin
         px.led_index  = 11'($urandom_range(0, LED_COUNT - 1));
         px.hue        = 10'($urandom_range(0, 359));
         px.saturation = ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      end else begin
         px.led_index  = 11'($urandom);
         px.hue        = 10'($urandom);
         px.saturation = 8'($urandom);
      end
      return px;
   endfunction

   // Idling is on in two of every three stretches and off near the end
   function automatic bit idling_allowed(int phase_count, int phase_sel);
      return pending_pixels.size() > CALM_TAIL && ((phase_count / 40) % 3) != phase_sel;
   endfunction

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  = 0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            predicted_colors.push_back(hsv_pixel_color(req_data));
         end
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_pixels.size() == 0) begin
            req_valid <= 1'b0;
         end else if (idling_allowed(pending_pixels.size(), 0) &&
                      $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(0, 3);
            req_valid <= 1'b0;
         end else begin
            req_data  <= pending_pixels.pop_front();
            req_valid <= 1'b1;
         end
      end
   end

   // Result monitor and stall generator
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            colors_seen++;
            if (predicted_colors.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX) begin
                  $display("unexpected color item: we=%0d slot=%0d rgb=%0d,%0d,%0d",
                           rsp_data.write_enable, rsp_data.led_slot,
                           rsp_data.red, rsp_data.green, rsp_data.blue);
               end
            end else begin
               want = predicted_colors.pop_front();
               if (rsp_data.write_enable !== want.write_enable ||
                   rsp_data.led_slot !== want.led_slot ||
                   rsp_data.red !== want.red ||
                   rsp_data.green !== want.green ||
                   rsp_data.blue !== want.blue) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_MAX) begin
                     $display("color mismatch: exp we=%0d slot=%0d rgb=%0d,%0d,%0d",
                              want.write_enable, want.led_slot,
                              want.red, want.green, want.blue);
                     $display("                got we=%0d slot=%0d rgb=%0d,%0d,%0d",
                              rsp_data.write_enable, rsp_data.led_slot,
                              rsp_data.red, rsp_data.green, rsp_data.blue);
                  end
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (idling_allowed(colors_seen, 1) && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 3);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("hsv_to_rgb_pixel_color_core test failed");
         $finish;
      end
   end

   initial begin
      // Directed: index edges, hue edges and clamp, every sector, grey
      pending_pixels.push_back(make_pixel(-1024, 100, 200, 255));
      pending_pixels.push_back(make_pixel(-1, 30, 255, 255));
      pending_pixels.push_back(make_pixel(LED_COUNT, 30, 255, 255));
      pending_pixels.push_back(make_pixel(1023, 1023, 255, 255));
      pending_pixels.push_back(make_pixel(0, 0, 255, 255));
      pending_pixels.push_back(make_pixel(LED_COUNT - 1, 59, 255, 255));
      pending_pixels.push_back(make_pixel(1, 60, 128, 200));
      pending_pixels.push_back(make_pixel(2, 90, 200, 180));
      pending_pixels.push_back(make_pixel(3, 150, 100, 255));
      pending_pixels.push_back(make_pixel(4, 210, 255, 77));
      pending_pixels.push_back(make_pixel(5, 270, 1, 255));
      pending_pixels.push_back(make_pixel(6, 330, 255, 1));
      pending_pixels.push_back(make_pixel(7, 359, 255, 255));
      pending_pixels.push_back(make_pixel(8, 360, 255, 255));
      pending_pixels.push_back(make_pixel(9, 1023, 180, 240));
      pending_pixels.push_back(make_pixel(10, 512, 90, 60));
      pending_pixels.push_back(make_pixel(11, 200, 0, 123));
      pending_pixels.push_back(make_pixel(12, 1023, 0, 255));
      pending_pixels.push_back(make_pixel(13, 45, 0, 0));
      pending_pixels.push_back(make_pixel(14, 120, 255, 0));
      pending_pixels.push_back(make_pixel(15, 240, 255, 255));
      pending_pixels.push_back(make_pixel(16, 300, 255, 255));
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         pending_pixels.push_back(random_pixel());
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      wait (pending_pixels.size() == 0);
      @(posedge clock);
      while (req_valid) @(posedge clock);
      wait (predicted_colors.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("hsv_to_rgb_pixel_color_core test passed");
      end else begin
         $display("hsv_to_rgb_pixel_color_core test failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/hsvrgb_pkg.sv
src/hsv_to_rgb_pixel_color_core.sv
verif/hsv_to_rgb_pixel_color_core_test.sv
